### hdl/lwps_pkg.sv
package lwps_pkg;

    localparam int CMD_W  = 2;
    localparam int SER_W  = 3;
    localparam int LAT_W  = 32;
    localparam int CNT_W  = 64;
    localparam int AVG_W  = 40;
    localparam int WS_W   = 11;
    localparam int FRAC_W = 8;

    localparam logic [WS_W-1:0] WS_RESET = 11'd1024;

    // restoring divide of {total, 8 fraction zeros} by count
    localparam int DIV_STEPS = CNT_W + FRAC_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for every x below 2^23
    localparam int              RECIP_W     = 24;
    localparam logic [23:0]     RECIP       = 24'd10737419;
    localparam int              RECIP_SHIFT = 30;

    localparam int PCT_N = 3;
    localparam int PCT_W = 7;
    localparam logic [PCT_W-1:0] PCT_Q [PCT_N] = '{7'd50, 7'd95, 7'd99};

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD    = 2'd0,
        CMD_READ      = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_CLEAR_ALL = 2'd3
    } t_cmd;

    typedef struct packed {
        logic take;
        logic div_step;
        logic kidx1;
        logic kidx2;
        logic scan;
        logic step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_last;
        logic win_empty;
        logic scan_done;
        logic last_bit;
        logic out_free;
    } t_ctrl_sts;

endpackage

### hdl/lwps_if.sv
interface lwps_cmd_if import lwps_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [SER_W-1:0] series_index;
    logic [LAT_W-1:0] latency;

    modport source (output valid, output command, output series_index, output latency,
                    input ready);
    modport sink   (input valid, input command, input series_index, input latency,
                    output ready);
endinterface

interface lwps_cfg_if import lwps_pkg::*;;
    logic            valid;
    logic            ready;
    logic [WS_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

interface lwps_res_if import lwps_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] sample_count;
    logic [LAT_W-1:0] minimum_latency;
    logic [LAT_W-1:0] maximum_latency;
    logic [AVG_W-1:0] average_latency;
    logic [LAT_W-1:0] median_latency;
    logic [LAT_W-1:0] p95_latency;
    logic [LAT_W-1:0] p99_latency;

    modport source (output valid, output sample_count, output minimum_latency,
                    output maximum_latency, output average_latency, output median_latency,
                    output p95_latency, output p99_latency, input ready);
    modport sink   (input valid, input sample_count, input minimum_latency,
                    input maximum_latency, input average_latency, input median_latency,
                    input p95_latency, input p99_latency, output ready);
endinterface

### hdl/lwps_ram.sv
module lwps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### hdl/lwps_ctrl.sv
module lwps_ctrl import lwps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_command,
    input  t_ctrl_sts        i_sts,
    output logic             o_in_ready,
    output t_ctrl_cmd        o_ctl
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_KIDX1 = 7'b0000100,
        ST_KIDX2 = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_STEP  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   take;

    assign o_in_ready = (r_state == ST_IDLE);
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        o_ctl          = '0;
        o_ctl.take     = take;
        case (r_state)
            ST_IDLE: begin
                if (take && t_cmd'(i_in_command) == CMD_READ) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_KIDX1;
                end
            end
            ST_KIDX1: begin
                o_ctl.kidx1 = 1'b1;
                n_state     = ST_KIDX2;
            end
            ST_KIDX2: begin
                o_ctl.kidx2 = 1'b1;
                n_state     = i_sts.win_empty ? ST_OUT : ST_SCAN;
            end
            ST_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                o_ctl.step = 1'b1;
                n_state    = i_sts.last_bit ? ST_OUT : ST_SCAN;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/lwps_dp.sv
module lwps_dp import lwps_pkg::*; #(
    parameter int MAX_WINDOW   = 1024,
    parameter int SERIES_COUNT = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctrl_cmd        i_ctl,
    output t_ctrl_sts        o_sts,
    input  logic [CMD_W-1:0] i_command,
    input  logic [SER_W-1:0] i_series_index,
    input  logic [LAT_W-1:0] i_latency,
    input  logic             i_cfg_wr,
    input  logic [WS_W-1:0]  i_window_size,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [CNT_W-1:0] o_sample_count,
    output logic [LAT_W-1:0] o_minimum_latency,
    output logic [LAT_W-1:0] o_maximum_latency,
    output logic [AVG_W-1:0] o_average_latency,
    output logic [LAT_W-1:0] o_median_latency,
    output logic [LAT_W-1:0] o_p95_latency,
    output logic [LAT_W-1:0] o_p99_latency
);

    localparam int FW    = $clog2(MAX_WINDOW + 1);
    localparam int PW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW    = (SERIES_COUNT > 1) ? $clog2(SERIES_COUNT) : 1;
    localparam int DEPTH = SERIES_COUNT * MAX_WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KXW   = FW + PCT_W;
    localparam int KPW   = KXW + RECIP_W;

    // per-series state
    logic [CNT_W-1:0] r_cnt_s  [SERIES_COUNT];
    logic [CNT_W-1:0] r_tot_s  [SERIES_COUNT];
    logic [LAT_W-1:0] r_min_s  [SERIES_COUNT];
    logic [LAT_W-1:0] r_max_s  [SERIES_COUNT];
    logic [FW-1:0]    r_fill_s [SERIES_COUNT];
    logic [PW-1:0]    r_pos_s  [SERIES_COUNT];
    logic [WS_W-1:0]  r_ws;

    // read-side working registers
    logic [SW-1:0]     r_ser;
    logic [FW-1:0]     r_n;
    logic [CNT_W-1:0]  r_snap_cnt;
    logic [LAT_W-1:0]  r_snap_min, r_snap_max;
    logic [CNT_W-1:0]  r_rem;
    logic [DIV_STEPS-1:0] r_dvd;
    logic [AVG_W-1:0]  r_quo;
    logic [DIV_CW-1:0] r_div_cnt;
    logic [KXW-1:0]    r_kx   [PCT_N];
    logic [FW-1:0]     r_k    [PCT_N];
    logic [FW-1:0]     r_hits [PCT_N];
    logic [LAT_W-1:0]  r_pref [PCT_N];
    logic [LAT_W-1:0]  r_bit, r_mask;
    logic [FW-1:0]     r_iss;
    logic              r_pend;
    logic              r_out_vld;

    logic [SW-1:0]    s;
    logic             s_ok;
    logic [31:0]      ws32, w32;
    logic [FW-1:0]    w;
    logic [FW-1:0]    cur_fill;
    logic             room;
    logic [PW-1:0]    p0, pnext, slot;
    logic [31:0]      p1_32;
    logic [CNT_W-1:0] cnt_inc;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic             wr_en, rd_en;
    logic [LAT_W-1:0] rd_data;
    logic [CNT_W:0]   trial, diff;
    logic             ge;
    logic             is_rec, is_clr, is_clr_all, is_read;
    logic             out_free;

    assign s          = SW'(i_series_index);
    assign s_ok       = 32'(i_series_index) < SERIES_COUNT;
    assign is_rec     = i_ctl.take && t_cmd'(i_command) == CMD_RECORD;
    assign is_read    = i_ctl.take && t_cmd'(i_command) == CMD_READ;
    assign is_clr     = i_ctl.take && t_cmd'(i_command) == CMD_CLEAR;
    assign is_clr_all = i_ctl.take && t_cmd'(i_command) == CMD_CLEAR_ALL;

    // effective window: zero acts as one, clamp to the store depth
    assign ws32 = 32'(r_ws);
    assign w32  = (ws32 == 32'd0) ? 32'd1 :
                  (ws32 > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : ws32;
    assign w    = FW'(w32);

    assign cur_fill = r_fill_s[s];
    assign room     = cur_fill < w;
    assign p0       = (32'(r_pos_s[s]) >= w32) ? '0 : r_pos_s[s];
    assign p1_32    = 32'(p0) + 32'd1;
    assign pnext    = (p1_32 >= w32) ? '0 : PW'(p1_32);
    assign slot     = room ? PW'(cur_fill) : p0;
    assign cnt_inc  = r_cnt_s[s] + CNT_W'(1);

    assign wr_en   = is_rec && s_ok;
    assign wr_addr = AW'(32'(s) * MAX_WINDOW + 32'(slot));
    assign rd_en   = i_ctl.scan && (r_iss != r_n);
    assign rd_addr = AW'(32'(r_ser) * MAX_WINDOW + 32'(r_iss));

    lwps_ram #(.WIDTH(LAT_W), .DEPTH(DEPTH)) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_latency),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= WS_RESET;
            for (int i = 0; i < SERIES_COUNT; i++) begin
                r_cnt_s[i]  <= '0;
                r_tot_s[i]  <= '0;
                r_min_s[i]  <= '0;
                r_max_s[i]  <= '0;
                r_fill_s[i] <= '0;
                r_pos_s[i]  <= '0;
            end
        end else begin
            if (i_cfg_wr) begin
                r_ws <= i_window_size;
            end
            if (is_rec && s_ok) begin
                r_cnt_s[s] <= cnt_inc;
                r_tot_s[s] <= r_tot_s[s] + CNT_W'(i_latency);
                if (cnt_inc == CNT_W'(1) || i_latency < r_min_s[s]) begin
                    r_min_s[s] <= i_latency;
                end
                if (i_latency > r_max_s[s]) begin
                    r_max_s[s] <= i_latency;
                end
                if (room) begin
                    r_fill_s[s] <= cur_fill + FW'(1);
                end else begin
                    r_pos_s[s] <= pnext;
                end
            end
            if (is_clr && s_ok) begin
                r_cnt_s[s]  <= '0;
                r_tot_s[s]  <= '0;
                r_min_s[s]  <= '0;
                r_max_s[s]  <= '0;
                r_fill_s[s] <= '0;
                r_pos_s[s]  <= '0;
            end
            if (is_clr_all) begin
                for (int i = 0; i < SERIES_COUNT; i++) begin
                    r_cnt_s[i]  <= '0;
                    r_tot_s[i]  <= '0;
                    r_min_s[i]  <= '0;
                    r_max_s[i]  <= '0;
                    r_fill_s[i] <= '0;
                    r_pos_s[i]  <= '0;
                end
            end
        end
    end

    // one quotient bit per cycle
    assign trial = {r_rem, r_dvd[DIV_STEPS-1]};
    assign diff  = trial - {1'b0, r_snap_cnt};
    assign ge    = trial >= {1'b0, r_snap_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_cnt <= '0;
            r_snap_min <= '0;
            r_snap_max <= '0;
            r_rem      <= '0;
            r_n        <= '0;
            r_iss      <= '0;
            r_pend     <= 1'b0;
            r_div_cnt  <= '0;
            r_bit      <= '0;
            r_mask     <= '0;
            for (int t = 0; t < PCT_N; t++) begin
                r_pref[t] <= '0;
                r_hits[t] <= '0;
            end
        end else begin
            r_pend <= rd_en;
            if (is_read) begin
                r_ser     <= s;
                r_rem     <= '0;
                r_quo     <= '0;
                r_div_cnt <= '0;
                r_iss     <= '0;
                r_bit     <= {1'b1, {(LAT_W-1){1'b0}}};
                r_mask    <= '0;
                for (int t = 0; t < PCT_N; t++) begin
                    r_pref[t] <= '0;
                    r_hits[t] <= '0;
                end
                if (s_ok) begin
                    r_snap_cnt <= r_cnt_s[s];
                    r_snap_min <= r_min_s[s];
                    r_snap_max <= r_max_s[s];
                    r_n        <= r_fill_s[s];
                    r_dvd      <= {r_tot_s[s], {FRAC_W{1'b0}}};
                end else begin
                    r_snap_cnt <= '0;
                    r_snap_min <= '0;
                    r_snap_max <= '0;
                    r_n        <= '0;
                    r_dvd      <= '0;
                end
            end
            if (i_ctl.div_step) begin
                r_rem     <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                r_quo     <= {r_quo[AVG_W-2:0], ge};
                r_dvd     <= r_dvd << 1;
                r_div_cnt <= r_div_cnt + DIV_CW'(1);
            end
            // target rank q*(n-1)/100, two multiply stages
            if (i_ctl.kidx1) begin
                for (int t = 0; t < PCT_N; t++) begin
                    r_kx[t] <= KXW'(r_n - FW'(1)) * KXW'(PCT_Q[t]);
                end
            end
            if (i_ctl.kidx2) begin
                for (int t = 0; t < PCT_N; t++) begin
                    r_k[t] <= FW'((KPW'(r_kx[t]) * KPW'(RECIP)) >> RECIP_SHIFT);
                end
            end
            if (rd_en) begin
                r_iss <= r_iss + FW'(1);
            end
            // count samples under the current prefix with a zero in this bit
            if (r_pend) begin
                for (int t = 0; t < PCT_N; t++) begin
                    if ((((rd_data ^ r_pref[t]) & r_mask) == '0) &&
                        ((rd_data & r_bit) == '0)) begin
                        r_hits[t] <= r_hits[t] + FW'(1);
                    end
                end
            end
            if (i_ctl.step) begin
                for (int t = 0; t < PCT_N; t++) begin
                    if (r_k[t] >= r_hits[t]) begin
                        r_pref[t] <= r_pref[t] | r_bit;
                        r_k[t]    <= r_k[t] - r_hits[t];
                    end
                    r_hits[t] <= '0;
                end
                r_mask <= r_mask | r_bit;
                r_bit  <= r_bit >> 1;
                r_iss  <= '0;
            end
        end
    end

    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            o_sample_count    <= r_snap_cnt;
            o_minimum_latency <= r_snap_min;
            o_maximum_latency <= r_snap_max;
            o_average_latency <= (r_snap_cnt == '0) ? '0 : r_quo;
            o_median_latency  <= r_pref[0];
            o_p95_latency     <= r_pref[1];
            o_p99_latency     <= r_pref[2];
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_sts.div_last  = (r_div_cnt == DIV_CW'(DIV_STEPS - 1));
    assign o_sts.win_empty = (r_n == '0);
    assign o_sts.scan_done = (r_iss == r_n) && !r_pend;
    assign o_sts.last_bit  = r_bit[0];
    assign o_sts.out_free  = out_free;

    a_pct_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load_out |-> (r_pref[0] <= r_pref[1]) && (r_pref[1] <= r_pref[2]))
        else $error("percentiles out of order");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.load_out && r_snap_cnt != '0) |-> r_snap_min <= r_snap_max)
        else $error("minimum above maximum");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.div_step && r_snap_cnt != '0) |=> r_rem < r_snap_cnt)
        else $error("divider remainder not below divisor");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load_out |=> r_out_vld)
        else $error("result not presented after load");

endmodule

### hdl/latency_window_percentile_stats.sv
// Latency statistics for SERIES_COUNT series with a ring of the last window_size
// samples each. Record, clear and clear-all commands leave the block ready for
// the next command. A read runs the average divider (one quotient bit a cycle),
// forms the percentile ranks, then makes 32 radix passes over the n held samples
// through the sample RAM read port (none with an empty window) and loads the
// result, no commands being taken meanwhile. The result sits in an output
// register, so a read result may wait while records continue.
module latency_window_percentile_stats import lwps_pkg::*; #(
    parameter int MAX_WINDOW   = 1024,
    parameter int SERIES_COUNT = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lwps_cmd_if.sink     i_cmd,
    lwps_cfg_if.sink     i_cfg,
    lwps_res_if.source   o_res
);

    t_ctrl_cmd ctl;
    t_ctrl_sts sts;

    assign i_cfg.ready = 1'b1;

    lwps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_in_command(i_cmd.command),
        .i_sts       (sts),
        .o_in_ready  (i_cmd.ready),
        .o_ctl       (ctl)
    );

    lwps_dp #(.MAX_WINDOW(MAX_WINDOW), .SERIES_COUNT(SERIES_COUNT)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_command        (i_cmd.command),
        .i_series_index   (i_cmd.series_index),
        .i_latency        (i_cmd.latency),
        .i_cfg_wr         (i_cfg.valid),
        .i_window_size    (i_cfg.window_size),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_sample_count   (o_res.sample_count),
        .o_minimum_latency(o_res.minimum_latency),
        .o_maximum_latency(o_res.maximum_latency),
        .o_average_latency(o_res.average_latency),
        .o_median_latency (o_res.median_latency),
        .o_p95_latency    (o_res.p95_latency),
        .o_p99_latency    (o_res.p99_latency)
    );

endmodule
